@@ hw/rtl/mcfp_pkg.sv @@
// mcfp_pkg: constants, types and helpers for the motor command frame parser
// no dependencies; compiled first
package mcfp_pkg;

	localparam logic [7:0] StartByte = 8'h41;
	localparam logic [7:0] EndByte   = 8'h42;
	localparam logic [7:0] ZeroChar  = 8'h30;

	// frame positions: 0 start, 1..20 axis data, 21 trailer
	localparam int unsigned NumAxes  = 4;
	localparam int unsigned AxisBits = $clog2(NumAxes);
	localparam int unsigned PosBits  = 5;
	localparam int unsigned SlotBits = 3;

	localparam logic [PosBits-1:0]  PosIdle    = 5'd0;
	localparam logic [PosBits-1:0]  PosFirst   = 5'd1;
	localparam logic [PosBits-1:0]  PosLastData = 5'd20;
	localparam logic [PosBits-1:0]  PosTrailer = 5'd21;
	localparam logic [SlotBits-1:0] SlotDir    = 3'd0;
	localparam logic [SlotBits-1:0] SlotLast   = 3'd4;
	localparam logic [SlotBits-1:0] SlotCount  = 3'd5;

	typedef struct packed {
		logic dir_we;
		logic digit_we;
	} mcfp_axis_ctl_t;

	// one decimal step: acc*10 + (b - '0'), wrapped to 16 bits
	function automatic logic [15:0] digit_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] times_ten;
		times_ten = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
		return times_ten + {8'h00, b} - {8'h00, ZeroChar};
	endfunction

endpackage

@@ hw/rtl/mcfp_if.sv @@
// mcfp_if: valid/ready channel interfaces for the byte input and the command output
// depends on nothing but the clockless signals it carries
interface mcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] received_byte;

	modport source (output valid, output received_byte, input ready);
	modport sink (input valid, input received_byte, output ready);
endinterface

interface mcfp_cmd_if;
	logic        valid;
	logic        ready;
	logic        direction_1;
	logic [15:0] angle_delta_1;
	logic        direction_2;
	logic [15:0] angle_delta_2;
	logic        direction_3;
	logic [15:0] angle_delta_3;
	logic        direction_4;
	logic [15:0] angle_delta_4;

	modport source (
		output valid, input ready,
		output direction_1, output angle_delta_1, output direction_2, output angle_delta_2,
		output direction_3, output angle_delta_3, output direction_4, output angle_delta_4
	);
	modport sink (
		input valid, output ready,
		input direction_1, input angle_delta_1, input direction_2, input angle_delta_2,
		input direction_3, input angle_delta_3, input direction_4, input angle_delta_4
	);
endinterface

@@ hw/rtl/mcfp_axis_acc.sv @@
// mcfp_axis_acc: direction flag and running decimal value of one axis
// depends on mcfp_pkg
module mcfp_axis_acc import mcfp_pkg::*; (
	input  logic           clk,
	input  mcfp_axis_ctl_t ctl,
	input  logic [7:0]     data,
	output logic           direction,
	output logic [15:0]    angle_delta
);

	logic        dir_q;
	logic [15:0] acc_q;

	// direction byte opens the axis and clears the value
	always_ff @(posedge clk) begin
		if (ctl.dir_we) begin
			dir_q <= (data != ZeroChar);
			acc_q <= 16'h0000;
		end else if (ctl.digit_we) begin
			acc_q <= digit_step(acc_q, data);
		end
	end

	assign direction   = dir_q;
	assign angle_delta = acc_q;

endmodule

@@ hw/rtl/motor_command_frame_parser.sv @@
// motor_command_frame_parser: top level, frame tracking and result register
// depends on mcfp_pkg, mcfp_if, mcfp_axis_acc
//
// Takes one received byte per beat on rx and, for every well formed frame, gives one
// command beat on cmd. A frame is 'A', four axes of five bytes (direction byte, then
// four decimal digits, most significant first) and the trailer 'B': 22 bytes in all.
// Bytes outside a frame are ignored until 'A'; an 'A' inside a frame restarts it; a
// frame whose 22nd byte is not 'B' is dropped without any output. Direction is 1
// when the axis byte is not '0'. The value is the four digits taken as decimal with
// each byte minus '0' (non-digits included), wrapped to 16-bit two's complement.
// Rate: one byte per clock, also while a finished command waits on cmd, unless a
// trailer then reaches the input register (see below). The command is offered on cmd
// from the result register, which the accepted trailer beat loads from the input
// register. The values are built digit by digit as the bytes arrive
// (acc*10 + digit in each axis accumulator), so no frame buffer is kept and the
// trailer only copies the four axes into the result register. rx.ready drops only
// when a trailer waits in the input register while an earlier command still sits
// unaccepted on cmd. No clearing pass after reset.
module motor_command_frame_parser import mcfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mcfp_byte_if.sink     rx,
	mcfp_cmd_if.source    cmd
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame tracking: position, and axis/slot so no divide is needed
	logic [PosBits-1:0]  pos_q;
	logic [AxisBits-1:0] axis_q;
	logic [SlotBits-1:0] slot_q;

	// result register
	logic        out_valid_q;
	logic [NumAxes-1:0] dir_res_q;
	logic [15:0] delta_res_q [NumAxes];

	logic        emit_s1;
	logic        go_s1;
	logic        proc_s1;
	logic        in_frame;
	logic        store_s1;
	logic        is_start;
	logic [NumAxes-1:0] axis_dir;
	logic [15:0] axis_delta [NumAxes];
	mcfp_axis_ctl_t axis_ctl [NumAxes];

	// a trailer 'B' produces a command; it may only leave s1 if the result register frees up
	assign in_frame = (pos_q != PosIdle) && (pos_q <= PosTrailer);
	assign is_start = (byte_s1 == StartByte);
	assign emit_s1  = valid_s1 && (pos_q == PosTrailer) && (byte_s1 == EndByte);
	assign go_s1    = !emit_s1 || !out_valid_q || cmd.ready;
	assign proc_s1  = valid_s1 && go_s1;
	assign store_s1 = proc_s1 && in_frame && !is_start && (pos_q <= PosLastData);

	assign rx.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.received_byte;
		end
	end

	// frame position update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PosIdle;
			axis_q <= '0;
			slot_q <= SlotDir;
		end else if (proc_s1) begin
			if (!in_frame || is_start) begin
				// waiting, or restart on a start byte
				pos_q  <= is_start ? PosFirst : PosIdle;
				axis_q <= '0;
				slot_q <= SlotDir;
			end else if (pos_q <= PosLastData) begin
				pos_q <= pos_q + PosFirst;
				if (slot_q == SlotLast) begin
					slot_q <= SlotDir;
					axis_q <= axis_q + AxisBits'(1);
				end else begin
					slot_q <= slot_q + SlotBits'(1);
				end
			end else begin
				// trailer: frame closes whatever the byte
				pos_q <= PosIdle;
			end
		end
	end

	// per-axis accumulators
	for (genvar k = 0; k < NumAxes; k++) begin : g_axis
		assign axis_ctl[k].dir_we   = store_s1 && (axis_q == AxisBits'(k)) && (slot_q == SlotDir);
		assign axis_ctl[k].digit_we = store_s1 && (axis_q == AxisBits'(k)) && (slot_q != SlotDir);

		mcfp_axis_acc u_axis (
			.clk         (clk),
			.ctl         (axis_ctl[k]),
			.data        (byte_s1),
			.direction   (axis_dir[k]),
			.angle_delta (axis_delta[k])
		);
	end

	// result register: holds a command until cmd takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && emit_s1) begin
			dir_res_q   <= axis_dir;
			delta_res_q <= axis_delta;
		end
	end

	assign cmd.valid         = out_valid_q;
	assign cmd.direction_1   = dir_res_q[0];
	assign cmd.angle_delta_1 = delta_res_q[0];
	assign cmd.direction_2   = dir_res_q[1];
	assign cmd.angle_delta_2 = delta_res_q[1];
	assign cmd.direction_3   = dir_res_q[2];
	assign cmd.angle_delta_3 = delta_res_q[2];
	assign cmd.direction_4   = dir_res_q[3];
	assign cmd.angle_delta_4 = delta_res_q[3];

	// a new command only follows a trailer byte seen at the trailer position
	a_emit_from_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pos_q == PosTrailer) && $past(byte_s1 == EndByte))
		else $error("command issued without a trailer");

	// position never leaves the frame range
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosTrailer)
		else $error("frame position out of range");

	// axis and slot track the data position
	a_axis_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != PosIdle && pos_q <= PosLastData) |->
		(pos_q == PosBits'(axis_q) * PosBits'(SlotCount) + PosBits'(slot_q) + PosFirst))
		else $error("axis/slot out of step with position");

	// a trailer blocked by a full result register waits in s1 untouched
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> valid_s1 && $stable(byte_s1) && $stable(pos_q))
		else $error("stalled trailer lost");

endmodule

@@ verif/mcfp_frame_checker.sv @@
`timescale 1ns / 100ps
// mcfp_frame_checker: watches the byte and command channels, predicts each command
// beat from the accepted bytes and compares it field by field; needs mcfp_pkg and mcfp_if
module mcfp_frame_checker import mcfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mcfp_byte_if        rx,
	mcfp_cmd_if         cmd,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [NumAxes-1:0]       direction;
		logic [NumAxes-1:0][15:0] angle_delta;
	} axis_command_t;

	// positions 1..20 of the frame being gathered
	logic [7:0]         frame_store [PosLastData];
	logic [PosBits-1:0] next_pos;
	axis_command_t      pending_commands [$];
	int unsigned        error_total;

	always @(posedge clk or negedge arst_n) begin : watch
		axis_command_t want;
		axis_command_t got;
		logic [7:0]    b;
		int            base;
		int            sum;
		if (!arst_n) begin
			next_pos = PosIdle;
			pending_commands.delete();
			error_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (rx.valid && rx.ready) begin
				b = rx.received_byte;
				if (next_pos == PosIdle || next_pos > PosTrailer) begin
					next_pos = (b == StartByte) ? PosFirst : PosIdle;
				end else if (b == StartByte) begin
					next_pos = PosFirst;
				end else if (next_pos <= PosLastData) begin
					frame_store[next_pos - PosFirst] = b;
					next_pos = next_pos + 1'b1;
				end else begin
					// trailer position: only a good trailer yields a command
					next_pos = PosIdle;
					if (b == EndByte) begin
						for (int k = 0; k < NumAxes; k++) begin
							base = k * int'(SlotCount);
							want.direction[k] = (frame_store[base + int'(SlotDir)] != ZeroChar);
							sum = 0;
							for (int d = 1; d <= int'(SlotLast); d++)
								sum = sum * 10 + (int'(frame_store[base + d]) - int'(ZeroChar));
							want.angle_delta[k] = sum[15:0];
						end
						pending_commands.push_back(want);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				got.direction = {cmd.direction_4, cmd.direction_3,
					cmd.direction_2, cmd.direction_1};
				got.angle_delta = {cmd.angle_delta_4, cmd.angle_delta_3,
					cmd.angle_delta_2, cmd.angle_delta_1};
				if (pending_commands.size() == 0) begin
					$error("command beat with no frame pending");
					error_total++;
				end else begin
					want = pending_commands.pop_front();
					for (int k = 0; k < NumAxes; k++) begin
						if (got.direction[k] !== want.direction[k]) begin
							$error("direction_%0d: expected %0b, actual %0b",
								k + 1, want.direction[k], got.direction[k]);
							error_total++;
						end
						if (got.angle_delta[k] !== want.angle_delta[k]) begin
							$error("angle_delta_%0d: expected %0d, actual %0d", k + 1,
								$signed(want.angle_delta[k]), $signed(got.angle_delta[k]));
							error_total++;
						end
					end
				end
			end
			mismatches <= error_total;
			outstanding <= pending_commands.size();
		end
	end

endmodule

@@ verif/motor_command_frame_parser_test.sv @@
`timescale 1ns / 100ps
// motor_command_frame_parser_test: drives bytes and command back-pressure into the parser
// and gives the verdict; needs mcfp_pkg, mcfp_if, the parser and mcfp_frame_checker
module motor_command_frame_parser_test;
	import mcfp_pkg::*;

	// a frame body is positions 1..20: per axis a direction byte and four digits
	typedef logic [7:0] frame_body_t [PosLastData];

	// kinds of random stimulus chunk
	typedef enum int {
		ChunkGood,        // well formed frame, decimal digits
		ChunkWild,        // well formed frame, any non-start byte as content
		ChunkBadTrailer,  // full frame whose last byte is not the end byte
		ChunkCutShort,    // start and part of a body, then the next start reopens
		ChunkNoise        // loose bytes between frames
	} chunk_kind_t;

	localparam int unsigned BytesPerPhase = 425;
	localparam int unsigned HoldCycles    = 400;
	localparam int unsigned NumPhases     = 4;

	// idling per phase: none, sender only, receiver only, both
	localparam int unsigned SenderIdlePct [NumPhases]    = '{0, 46, 0, 29};
	localparam int unsigned ReceiverStallPct [NumPhases] = '{0, 0, 46, 29};

	logic clk = 1'b0;
	logic arst_n;

	mcfp_byte_if rx_bus ();
	mcfp_cmd_if  cmd_bus ();

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned framed_bytes;
	bit          hold_request;
	int unsigned mismatch_count;
	int unsigned commands_outstanding;

	motor_command_frame_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_bus),
		.cmd    (cmd_bus)
	);

	mcfp_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_bus),
		.cmd         (cmd_bus),
		.mismatches  (mismatch_count),
		.outstanding (commands_outstanding)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the parser wedges
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// any byte except the start byte, so it lands in the body instead of reopening
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == StartByte);
		return b;
	endfunction

	// turn a 20 character string into a body, first character at position 1
	function automatic frame_body_t body_of(input string s);
		frame_body_t body;
		for (int i = 0; i < PosLastData; i++)
			body[i] = s[i];
		return body;
	endfunction

	// random body: direction byte is '0' half the time, digits either decimal or wild
	function automatic frame_body_t random_body(input bit decimal_only);
		frame_body_t body;
		for (int k = 0; k < NumAxes; k++) begin
			body[k * SlotCount] = $urandom_range(1) ? ZeroChar : body_byte();
			for (int d = 1; d <= SlotLast; d++)
				body[k * SlotCount + d] = decimal_only ?
					ZeroChar + 8'($urandom_range(9)) : body_byte();
		end
		return body;
	endfunction

	// offer one byte, with random idle cycles ahead of it, and hold it until accepted;
	// valid is left high so back-to-back bytes never drop it for a cycle
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			rx_bus.valid <= 1'b0;
			@(posedge clk);
		end
		rx_bus.valid <= 1'b1;
		rx_bus.received_byte <= b;
		@(posedge clk);
		while (!rx_bus.ready)
			@(posedge clk);
	endtask

	task automatic send_frame(input frame_body_t body, input logic [7:0] trailer);
		send_byte(StartByte);
		foreach (body[i])
			send_byte(body[i]);
		send_byte(trailer);
		framed_bytes += PosTrailer + 1;
	endtask

	// lower valid, let the checker count the last accepted byte, then wait for it
	// to see every command it expects
	task automatic drain();
		rx_bus.valid <= 1'b0;
		@(posedge clk);
		while (commands_outstanding != 0)
			@(posedge clk);
	endtask

	// command side: random back-pressure, or a long hold-off when the stimulus asks
	// for one, counted here so the sender keeps pushing bytes meanwhile
	initial begin
		cmd_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				cmd_bus.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				cmd_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	initial begin
		chunk_kind_t kind;
		frame_body_t body;
		logic [7:0]  trailer;
		int unsigned roll;
		int unsigned cut_len;

		rx_bus.valid = 1'b0;
		rx_bus.received_byte = 8'h00;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		framed_bytes = 0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// bytes while waiting for a start, including a stray end byte, are ignored
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(EndByte);
		// plain decimal frame, mixed direction bytes
		send_frame(body_of("00000199991123403579"), EndByte);
		// extremes: axis 1 direction 0x00 with digits 0xFF, axis 2 direction 0xFF with
		// digits 0x00, so the value wraps both ways; axes 3 and 4 carry 9999 and 0000
		body = body_of("xxxxxxxxxx0999910000");
		body[0] = 8'h00;
		for (int d = 1; d <= SlotLast; d++) begin
			body[d] = 8'hFF;
			body[SlotCount + d] = 8'h00;
		end
		body[SlotCount] = 8'hFF;
		send_frame(body, EndByte);
		// start byte inside a frame drops the partial frame and reopens it
		send_byte(StartByte);
		send_byte("1");
		send_byte("2");
		send_byte("3");
		send_frame(body_of("15555065430777714321"), EndByte);
		// bad trailers: silently dropped, back to waiting
		send_frame(body_of("11111022220333304444"), 8'hBD);
		// start byte in the trailer slot reopens; the next start reopens again
		send_frame(body_of("19876012340567801111"), StartByte);
		send_frame(body_of("02468113579024680000"), EndByte);
		drain();

		// random part, one phase per idling mix
		for (int phase = 0; phase < NumPhases; phase++) begin
			sender_idle_pct = SenderIdlePct[phase];
			receiver_stall_pct = ReceiverStallPct[phase];
			framed_bytes = 0;
			if (phase == 0) begin
				// command side held off while several good frames come in, so the
				// result register stays full and a later trailer stalls the input
				hold_request = 1'b1;
				repeat (4) send_frame(random_body(1'b1), EndByte);
			end
			while (framed_bytes < BytesPerPhase) begin
				roll = $urandom_range(99);
				kind = (roll < 55) ? ChunkGood :
					(roll < 70) ? ChunkWild :
					(roll < 80) ? ChunkBadTrailer :
					(roll < 90) ? ChunkCutShort : ChunkNoise;
				case (kind)
					ChunkGood: begin
						send_frame(random_body(1'b1), EndByte);
					end
					ChunkWild: begin
						send_frame(random_body(1'b0), EndByte);
					end
					ChunkBadTrailer: begin
						do
							trailer = 8'($urandom_range(255));
						while (trailer == EndByte);
						send_frame(random_body(1'($urandom_range(1))), trailer);
					end
					ChunkCutShort: begin
						// up to a full body; a full one leaves the parser on the trailer slot
						cut_len = $urandom_range(1, PosLastData);
						send_byte(StartByte);
						repeat (cut_len) send_byte(body_byte());
						framed_bytes += cut_len + 1;
					end
					default: begin
						// loose bytes may include a start byte, which opens a frame
						// that the next chunk reopens
						repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
					end
				endcase
			end
			// sender pauses until every command of the phase is out
			drain();
		end

		// let the two-stage pipe settle so a spurious beat would still be seen
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && commands_outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mcfp_pkg.sv
hw/rtl/mcfp_if.sv
hw/rtl/mcfp_axis_acc.sv
hw/rtl/motor_command_frame_parser.sv
verif/mcfp_frame_checker.sv
verif/motor_command_frame_parser_test.sv
